// ===== hw/rtl/ordq_pkg.sv =====
`timescale 1ns / 1ps

package ordq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEPTH_DEFAULT = 16;

  localparam int REQ_W = 2;
  localparam logic [REQ_W-1:0] REQ_APPEND    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIND      = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_FIRST = 2'd3;

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  // Controls broadcast to every cell of the row.
  typedef struct packed {
    logic shift;   // take the right neighbor's entry (remove first)
    logic cmp;     // compare entry against the search value
    logic mshift;  // take the right neighbor's match flag (scan step)
  } cell_ctl_t;

endpackage

// ===== hw/rtl/ordq_cell.sv =====
`timescale 1ns / 1ps

module ordq_cell
  import ordq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctl_t         ctl,
  input  logic              load,
  input  logic              valid,
  input  logic [DATA_W-1:0] value,
  input  logic [DATA_W-1:0] right_data,
  input  logic              right_match,
  output logic [DATA_W-1:0] data,
  output logic              match
);

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              match_r, match_nxt;

  always_comb begin
    data_nxt = data_r;
    if (load) begin
      data_nxt = value;
    end else if (ctl.shift) begin
      data_nxt = right_data;
    end
  end

  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp) begin
      match_nxt = valid && (data_r == value);
    end else if (ctl.mshift) begin
      match_nxt = right_match;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

// ===== hw/rtl/ordered_deque_with_search.sv =====
`timescale 1ns / 1ps
// Channel | Direction | tdata (low bit up)                     | tuser
// in_     | slave     | value[31:0]                            | req_type[1:0]
// out_    | master    | found_index[IW-1:0], entry_total[CW-1:0] | status[1:0]
//
// Append and both removes finish in the accept cycle; the result item shows in
//   the next cycle. A find compares in the accept cycle, then scans up to
//   entry_total positions as the match flags walk the cell row toward cell 0.
// A new item is accepted only with no find in progress and the output register
//   free or being taken in the same cycle.
// Reset (rst_n low at a clock edge) empties the list; entries are not cleared.
// A stall on out_tready holds the result item and blocks the next input item.

module ordered_deque_with_search
  import ordq_pkg::*;
#(
  parameter  int DEPTH = DEPTH_DEFAULT,
  localparam int IW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OUT_W = ((IW + CW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // value[31:0]
  input  logic [REQ_W-1:0]  in_tuser,   // req_type[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // found_index, entry_total, zero fill
  output logic [ST_W-1:0]   out_tuser   // status[1:0]
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic              state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     k_r, k_nxt;           // scan step = logical position at cell 0
  logic              out_valid_r;
  logic [ST_W-1:0]   status_r;
  logic [IW-1:0]     idx_r;
  logic [CW-1:0]     total_r;

  logic              in_go;
  logic              append_go;
  logic              res_go;
  logic [ST_W-1:0]   res_status;
  logic [IW-1:0]     res_idx;
  cell_ctl_t         ctl;

  logic [DATA_W-1:0] cell_data  [DEPTH];
  logic              cell_match [DEPTH];

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_go     = in_tvalid && in_tready;

  // Request decode and find scan control.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    k_nxt      = k_r;
    append_go  = 1'b0;
    res_go     = 1'b0;
    res_status = ST_DONE;
    res_idx    = '0;
    ctl        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_go) begin
          case (in_tuser)
            REQ_APPEND: begin
              res_go = 1'b1;
              if (count_r == CW'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                append_go = 1'b1;
                count_nxt = count_r + 1'b1;
              end
            end
            REQ_FIND: begin
              if (count_r == '0) begin
                res_go     = 1'b1;
                res_status = ST_NOT_FOUND;
              end else begin
                ctl.cmp   = 1'b1;
                k_nxt     = '0;
                state_nxt = S_SCAN;
              end
            end
            REQ_DEL_LAST: begin
              res_go = 1'b1;
              if (count_r == '0) begin
                res_status = ST_EMPTY;
              end else begin
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
              res_go = 1'b1;
              if (count_r == '0) begin
                res_status = ST_EMPTY;
              end else begin
                ctl.shift = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // Cell 0 holds the match flag of logical position k_r.
        if (cell_match[0]) begin
          res_go     = 1'b1;
          res_idx    = k_r;
          state_nxt  = S_IDLE;
        end else if (CW'(k_r) + 1'b1 == count_r) begin
          res_go     = 1'b1;
          res_status = ST_NOT_FOUND;
          state_nxt  = S_IDLE;
        end else begin
          ctl.mshift = 1'b1;
          k_nxt      = k_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Cell row in logical order: cell 0 is the head.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] right_data;
    logic              right_match;
    if (i == DEPTH - 1) begin : g_last
      assign right_data  = cell_data[i];
      assign right_match = 1'b0;
    end else begin : g_mid
      assign right_data  = cell_data[i+1];
      assign right_match = cell_match[i+1];
    end
    ordq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .load        (append_go && (count_r == CW'(i))),
      .valid       (CW'(i) < count_r),
      .value       (in_tdata),
      .right_data  (right_data),
      .right_match (right_match),
      .data        (cell_data[i]),
      .match       (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
      if (res_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; held while the output item waits.
  always_ff @(posedge clk) begin
    if (res_go) begin
      status_r <= res_status;
      idx_r    <= res_idx;
      total_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_W'({total_r, idx_r});

  // The output register is always free while a find scans.
  a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !out_valid_r)
    else $error("result pending during find scan");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // The scan never walks past the last held entry.
  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CW'(k_r) < count_r))
    else $error("scan step beyond entry count");

  a_del_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_go && in_tuser == REQ_DEL_FIRST && count_r != '0)
      |=> (count_r == $past(count_r) - 1'b1))
    else $error("remove first did not shrink the list");

  a_append_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_go && in_tuser == REQ_APPEND && count_r == CW'(DEPTH))
      |=> (out_valid_r && status_r == ST_FULL && count_r == CW'(DEPTH)))
    else $error("append to full list not flagged");

endmodule

// ===== bench/ordq_result_checker.sv =====
`timescale 1ns / 1ps

module ordq_result_checker
  import ordq_pkg::*;
#(
  parameter  int DEPTH = DEPTH_DEFAULT,
  localparam int IW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OUT_W = ((IW + CW + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,
  input  logic [REQ_W-1:0]  in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_W-1:0]  out_tdata,
  input  logic [ST_W-1:0]   out_tuser,
  output int                mismatches,
  output int                results_due
);

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [IW-1:0]   found_index;
    logic [CW-1:0]   entry_total;
  } reply_t;

  logic [DATA_W-1:0] held_values[$];
  reply_t            expected_replies[$];
  int                fail_total = 0;
  int                due_count  = 0;
  int                reply_seq  = 0;

  assign mismatches  = fail_total;
  assign results_due = due_count;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on reply %0d, %s: got %0d, expected %0d",
             $realtime, reply_seq, what, got, want);
    fail_total++;
  endtask

  // Update the shadow list for one request and queue the reply it must produce.
  task automatic apply_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val);
    reply_t r;
    r = '0;
    r.status = ST_DONE;
    case (req)
      REQ_APPEND: begin
        if (held_values.size() >= DEPTH) r.status = ST_FULL;
        else held_values.push_back(val);
      end
      REQ_FIND: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < held_values.size(); i++) begin
          if (r.status == ST_NOT_FOUND && held_values[i] == val) begin
            r.status      = ST_DONE;
            r.found_index = IW'(i);
          end
        end
      end
      REQ_DEL_LAST: begin
        if (held_values.size() == 0) r.status = ST_EMPTY;
        else void'(held_values.pop_back());
      end
      default: begin
        if (held_values.size() == 0) r.status = ST_EMPTY;
        else void'(held_values.pop_front());
      end
    endcase
    r.entry_total = CW'(held_values.size());
    expected_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n) begin
      // A reply always belongs to an older request, so retire before predicting.
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with nothing outstanding", out_tuser, 0);
        end else begin
          want = expected_replies.pop_front();
          if (out_tuser !== want.status)
            report_mismatch("status", out_tuser, want.status);
          if (out_tdata[IW-1:0] !== want.found_index)
            report_mismatch("found_index", out_tdata[IW-1:0], want.found_index);
          if (out_tdata[IW+CW-1:IW] !== want.entry_total)
            report_mismatch("entry_total", out_tdata[IW+CW-1:IW], want.entry_total);
        end
        reply_seq++;
      end
      if (in_tvalid && in_tready) apply_request(in_tuser, in_tdata);
      due_count <= expected_replies.size();
    end
  end

endmodule

// ===== bench/tb_ordered_deque_with_search.sv =====
`timescale 1ns / 1ps

module tb_ordered_deque_with_search;
  import ordq_pkg::*;

  localparam int DEPTH        = DEPTH_DEFAULT;
  localparam int IW           = $clog2(DEPTH);
  localparam int CW           = $clog2(DEPTH + 1);
  localparam int OUT_W        = ((IW + CW + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 1522;
  localparam int HOLD_CYCLES  = 80;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;  // value[31:0]
  logic [REQ_W-1:0]  in_tuser   = REQ_APPEND;  // req_type[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;  // found_index, entry_total, zero fill
  logic [ST_W-1:0]   out_tuser;  // status[1:0]

  int fail_count;
  int results_due;

  // Idle percentages per traffic phase: receiver-heavy idling, then
  // sender-heavy, then none at all.
  int phase = 0;
  int tx_idle_pct[3] = '{35, 46, 0};
  int rx_idle_pct[3] = '{46, 35, 0};
  bit hold_off_req = 1'b0;

  always #10 clk = ~clk;

  ordered_deque_with_search #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ordq_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (fail_count),
    .results_due (results_due)
  );

  // Offer one request at the falling edge and hold it until the block takes it.
  // Called at a falling edge; returns at the falling edge after acceptance, so
  // back-to-back requests keep tvalid high without a dip.
  task automatic offer_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct[phase]) begin
      in_tvalid <= 1'b0;
      in_tdata  <= $urandom;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= val;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly a small pool so finds hit and duplicates appear; sometimes an
  // extreme, sometimes a full random word so every bit toggles.
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] extremes[4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    int sel;
    sel = $urandom_range(9);
    if (sel <= 5) return $urandom_range(7) - 32'd4;
    else if (sel == 6) return extremes[$urandom_range(3)];
    else return $urandom;
  endfunction

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // output register fills and the input side stalls.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_tready   <= 1'b0;
        hold_off_req = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct[phase]);
      end
    end
  end

  initial begin
    logic [REQ_W-1:0] req;
    int append_pct;
    int r;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: removes and find on an empty list.
    offer_request(REQ_FIND, 32'h0);
    offer_request(REQ_DEL_LAST, 32'hFFFF_FFFF);
    offer_request(REQ_DEL_FIRST, 32'h0);
    // Extremes of the value field, then exact-match finds and a near miss.
    offer_request(REQ_APPEND, 32'h8000_0000);
    offer_request(REQ_APPEND, 32'h7FFF_FFFF);
    offer_request(REQ_APPEND, 32'h0);
    offer_request(REQ_APPEND, 32'hFFFF_FFFF);
    offer_request(REQ_FIND, 32'h7FFF_FFFF);
    offer_request(REQ_FIND, 32'hFFFF_FFFF);
    offer_request(REQ_FIND, 32'h7FFF_FFFE);
    // Drop both ends; removing the head shifts every entry toward cell 0.
    offer_request(REQ_DEL_FIRST, 32'h0);
    offer_request(REQ_DEL_LAST, 32'h0);
    // Fill with duplicates, then append to a full list.
    for (int i = 0; i < DEPTH - 2; i++) offer_request(REQ_APPEND, (i % 3) - 32'd1);
    offer_request(REQ_APPEND, 32'h1234_5678);
    offer_request(REQ_FIND, 32'hFFFF_FFFF);

    // Random: bias toward filling or draining in bursts so both full and
    // empty lists are visited often.
    append_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) phase = 1;
      if (n == 2 * RANDOM_ITEMS / 3) begin
        phase        = 2;
        hold_off_req = 1'b1;
      end
      if (n % 48 == 0) append_pct = 20 + 25 * $urandom_range(2);
      r = $urandom_range(99);
      if (r < append_pct) req = REQ_APPEND;
      else begin
        r = $urandom_range(9);
        req = (r < 4) ? REQ_FIND : (r < 7) ? REQ_DEL_LAST : REQ_DEL_FIRST;
      end
      offer_request(req, (req == REQ_DEL_LAST || req == REQ_DEL_FIRST) ? $urandom : pick_value());
    end
    in_tvalid <= 1'b0;

    // Drain, then give a full-length find time to surface anything stray.
    while (results_due != 0) @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("ordered_deque_with_search regression: pass");
    end else begin
      $display("ordered_deque_with_search regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("ordered_deque_with_search regression: fail");
    $finish;
  end

endmodule
